[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion helpers shared by the hunk encoder modules.
// Every check is sampled on the rising edge of clock and ignored in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define GCDH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Expression must never be true at a sampled edge.
`define GCDH_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

[hdl/gcdh_pkg.sv]
// ---------------------------------------------------------------------------
// gcdh_pkg
// Shared types and constants of the gap coalescing delta hunk encoder:
// record kinds and the command that the front end hands to the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package gcdh_pkg;

   localparam int VAL_W       = 64;
   localparam int OFF_W       = 16;
   // Slot and flush count fields cover the largest supported gap (8).
   localparam int SLOT_W      = 3;
   // Up to gap + 1 records per transaction.
   localparam int CNT_W       = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [1:0] {
      KIND_COMMON = 2'd0,
      KIND_FWD    = 2'd1,
      KIND_REV    = 2'd2,
      KIND_CLOSE  = 2'd3
   } kind_type;

   // Records of one command go out in this order:
   // hunk close, flushed pending pairs, element, final end marker.
   typedef struct packed {
      logic [CNT_W-1:0]  rec_cnt;
      logic              close_first;
      logic [SLOT_W-1:0] flush_cnt;
      logic              elem;
      kind_type          elem_kind;
      logic              elem_start;
      logic              fin;
      logic              store;
      logic [SLOT_W-1:0] store_slot;
      logic              ovf;
      logic [OFF_W-1:0]  offset;
      logic [VAL_W-1:0]  fwd_value;
      logic [VAL_W-1:0]  rev_value;
   } cmd_type;

endpackage

`default_nettype wire

[hdl/gcdh_front.sv]
// ---------------------------------------------------------------------------
// gcdh_front
// Accepts element pairs, compares them, tracks hunk and tail phase and
// turns each transaction into at most one command for the record sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gcdh_front #(
   parameter int MAX_ELEMENTS = 65536,
   parameter int GAP          = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [63:0]          req_old_value,
   input  logic [63:0]          req_new_value,
   input  logic                 req_has_old,
   input  logic                 req_has_new,
   input  logic                 req_final_item,
   input  logic                 q_full,
   output logic                 cmd_push,
   output gcdh_pkg::cmd_type    cmd
);
   import gcdh_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int PEND_W = (GAP > 1) ? $clog2(GAP) : 1;
   localparam logic [IDX_W-1:0]  IDX_MAX   = IDX_W'(MAX_ELEMENTS);
   localparam logic [IDX_W-1:0]  IDX_SAT   = IDX_W'(MAX_ELEMENTS - 1);
   localparam logic [PEND_W-1:0] PEND_LAST = PEND_W'(GAP - 1);

   typedef enum logic [1:0] {
      PH_COMMON,
      PH_FWD,
      PH_REV,
      PH_DRAINED
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               hunk_open_ff, hunk_open_in;
   logic [PEND_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic [IDX_W-1:0]   index_ff, index_in;

   logic               accept;
   logic               advance;
   logic               values_equal;
   logic               tail_present;
   logic [IDX_W-1:0]   off_sat;

   function automatic logic dbl_equal(input logic [63:0] a, input logic [63:0] b);
      logic [62:0] ma;
      logic [62:0] mb;
      logic        nan_any;
      ma      = a[62:0];
      mb      = b[62:0];
      nan_any = (ma > {11'h7FF, 52'h0}) || (mb > {11'h7FF, 52'h0});
      return !nan_any && (((ma == '0) && (mb == '0)) || (a == b));
   endfunction

   assign req_ready    = !q_full;
   assign accept       = req_valid && req_ready;
   assign values_equal = dbl_equal(req_old_value, req_new_value);
   assign off_sat      = (index_ff > IDX_SAT) ? IDX_SAT : index_ff;

   always_comb begin
      phase_in        = phase_ff;
      hunk_open_in    = hunk_open_ff;
      pend_cnt_in     = pend_cnt_ff;
      advance         = 1'b0;
      cmd.close_first = 1'b0;
      cmd.flush_cnt   = '0;
      cmd.elem        = 1'b0;
      cmd.elem_kind   = KIND_COMMON;
      cmd.elem_start  = 1'b0;
      cmd.store       = 1'b0;
      cmd.store_slot  = SLOT_W'(pend_cnt_ff);
      cmd.fwd_value   = req_new_value;
      cmd.rev_value   = req_old_value;
      cmd.fin         = req_final_item;
      cmd.ovf         = (index_ff == IDX_MAX);
      cmd.offset      = OFF_W'(off_sat);

      if (phase_ff == PH_COMMON) begin
         if (req_has_old && req_has_new) begin
            advance = 1'b1;
            if (!values_equal) begin
               cmd.elem = 1'b1;
               if (hunk_open_ff) begin
                  // flush the held equal pairs into the open hunk
                  cmd.flush_cnt = SLOT_W'(pend_cnt_ff);
                  pend_cnt_in   = '0;
               end else begin
                  cmd.elem_start = 1'b1;
                  hunk_open_in   = 1'b1;
               end
            end else if (hunk_open_ff) begin
               if (pend_cnt_ff == PEND_LAST) begin
                  // gap reached: close and drop the held pairs
                  cmd.close_first = 1'b1;
                  hunk_open_in    = 1'b0;
                  pend_cnt_in     = '0;
               end else begin
                  cmd.store   = 1'b1;
                  pend_cnt_in = pend_cnt_ff + PEND_W'(1);
               end
            end
         end else begin
            cmd.close_first = hunk_open_ff;
            hunk_open_in    = 1'b0;
            pend_cnt_in     = '0;
            phase_in        = req_has_new ? PH_FWD : (req_has_old ? PH_REV : PH_DRAINED);
         end
      end

      // take the tail side from the phase chosen above, before it can drain
      tail_present = (phase_in == PH_FWD) ? req_has_new : req_has_old;

      if ((phase_in == PH_FWD) || (phase_in == PH_REV)) begin
         if (tail_present) begin
            cmd.elem       = 1'b1;
            cmd.elem_start = !hunk_open_in;
            hunk_open_in   = 1'b1;
            advance        = 1'b1;
            if (phase_in == PH_FWD) begin
               cmd.elem_kind = KIND_FWD;
               cmd.rev_value = '0;
            end else begin
               cmd.elem_kind = KIND_REV;
               cmd.fwd_value = '0;
            end
         end else begin
            cmd.close_first = hunk_open_in;
            hunk_open_in    = 1'b0;
            pend_cnt_in     = '0;
            phase_in        = PH_DRAINED;
         end
      end

      index_in = (advance && (index_ff != IDX_MAX)) ? index_ff + IDX_W'(1) : index_ff;

      if (req_final_item) begin
         // end of diff: return to the idle common state
         phase_in     = PH_COMMON;
         hunk_open_in = 1'b0;
         pend_cnt_in  = '0;
         index_in     = '0;
      end

      cmd.rec_cnt = CNT_W'(cmd.close_first) + CNT_W'(cmd.flush_cnt)
                  + CNT_W'(cmd.elem) + CNT_W'(cmd.fin);
   end

   // drop commands that neither emit nor store anything
   assign cmd_push = accept && ((cmd.rec_cnt != '0) || cmd.store);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COMMON;
         hunk_open_ff <= 1'b0;
         pend_cnt_ff  <= '0;
         index_ff     <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hunk_open_ff <= hunk_open_in;
         pend_cnt_ff  <= pend_cnt_in;
         index_ff     <= index_in;
      end
   end

   `GCDH_ASSERT(a_pend_needs_hunk, !hunk_open_ff |-> (pend_cnt_ff == '0), "held pairs, no hunk")
   `GCDH_ASSERT(a_pend_common, (phase_ff != PH_COMMON) |-> (pend_cnt_ff == '0), "tail holds pairs")

endmodule

`default_nettype wire

[hdl/gcdh_queue.sv]
// ---------------------------------------------------------------------------
// gcdh_queue
// Short command queue between the front end and the record sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gcdh_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gcdh_pkg::cmd_type    push_data,
   input  logic                 pop,
   output gcdh_pkg::cmd_type    head,
   output logic                 head_valid,
   output logic                 full
);
   import gcdh_pkg::*;

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `GCDH_ASSERT_NEVER(a_no_overflow, push && full && !pop, "command pushed into full queue")

endmodule

`default_nettype wire

[hdl/gcdh_back.sv]
// ---------------------------------------------------------------------------
// gcdh_back
// Record sequencer: expands the head command into result records (one per
// cycle unless stalled), keeps held equal pairs, drives the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gcdh_back #(
   parameter int GAP = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gcdh_pkg::cmd_type    head,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_record_kind,
   output logic [15:0]          rsp_offset,
   output logic [63:0]          rsp_forward_value,
   output logic [63:0]          rsp_reverse_value,
   output logic                 rsp_hunk_start,
   output logic                 rsp_index_overflow,
   output logic                 rsp_last,
   output logic                 rsp_stream_done
);
   import gcdh_pkg::*;

   localparam int PEND_DEPTH = (GAP > 1) ? GAP - 1 : 1;
   localparam int BUF_IW     = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

   logic [VAL_W-1:0]  buf_old_ff [PEND_DEPTH];
   logic [VAL_W-1:0]  buf_new_ff [PEND_DEPTH];
   logic [CNT_W-1:0]  rec_k_ff;
   logic              rsp_valid_ff;
   kind_type          rsp_kind_ff;
   logic [OFF_W-1:0]  rsp_offset_ff;
   logic [VAL_W-1:0]  rsp_fwd_ff;
   logic [VAL_W-1:0]  rsp_rev_ff;
   logic              rsp_start_ff;
   logic              rsp_ovf_ff;
   logic              rsp_last_ff;
   logic              rsp_done_ff;

   logic              out_free;
   logic              null_cmd;
   logic              fire;
   logic              is_last_rec;
   logic [CNT_W-1:0]  close_end;
   logic [CNT_W-1:0]  flush_end;
   logic [CNT_W-1:0]  flush_j;
   logic [CNT_W-1:0]  flush_dist;
   logic [BUF_IW-1:0] rd_idx;
   logic              in_close;
   logic              in_flush;
   logic              in_elem;

   kind_type          rec_kind;
   logic [OFF_W-1:0]  rec_off;
   logic [VAL_W-1:0]  rec_fwd;
   logic [VAL_W-1:0]  rec_rev;
   logic              rec_start;
   logic              rec_done;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign null_cmd    = (head.rec_cnt == '0);
   assign fire        = head_valid && !null_cmd && out_free;
   assign is_last_rec = (rec_k_ff == head.rec_cnt - CNT_W'(1));
   assign pop         = head_valid && (null_cmd || (out_free && is_last_rec));

   assign close_end  = CNT_W'(head.close_first);
   assign flush_end  = close_end + CNT_W'(head.flush_cnt);
   assign flush_j    = rec_k_ff - close_end;
   assign flush_dist = CNT_W'(head.flush_cnt) - flush_j;
   assign rd_idx     = flush_j[BUF_IW-1:0];
   assign in_close   = (rec_k_ff < close_end);
   assign in_flush   = !in_close && (rec_k_ff < flush_end);
   assign in_elem    = !in_close && !in_flush && head.elem && (rec_k_ff == flush_end);

   always_comb begin
      rec_kind  = KIND_CLOSE;
      rec_off   = '0;
      rec_fwd   = '0;
      rec_rev   = '0;
      rec_start = 1'b0;
      rec_done  = 1'b0;
      priority if (in_close) begin
         rec_kind = KIND_CLOSE;
      end else if (in_flush) begin
         // held pair sits flush_dist elements behind the current one
         rec_kind = KIND_COMMON;
         rec_off  = head.offset - OFF_W'(flush_dist);
         rec_fwd  = buf_new_ff[rd_idx];
         rec_rev  = buf_old_ff[rd_idx];
      end else if (in_elem) begin
         rec_kind  = head.elem_kind;
         rec_off   = head.offset;
         rec_fwd   = head.fwd_value;
         rec_rev   = head.rev_value;
         rec_start = head.elem_start;
      end else begin
         rec_kind = KIND_CLOSE;
         rec_done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rec_k_ff     <= '0;
      end else begin
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            rec_k_ff     <= is_last_rec ? '0 : rec_k_ff + CNT_W'(1);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_kind_ff   <= rec_kind;
         rsp_offset_ff <= rec_off;
         rsp_fwd_ff    <= rec_fwd;
         rsp_rev_ff    <= rec_rev;
         rsp_start_ff  <= rec_start;
         rsp_ovf_ff    <= head.ovf;
         rsp_last_ff   <= is_last_rec;
         rsp_done_ff   <= rec_done;
      end
      if (pop && head.store) begin
         buf_old_ff[head.store_slot[BUF_IW-1:0]] <= head.rev_value;
         buf_new_ff[head.store_slot[BUF_IW-1:0]] <= head.fwd_value;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_kind    = rsp_kind_ff;
   assign rsp_offset         = rsp_offset_ff;
   assign rsp_forward_value  = rsp_fwd_ff;
   assign rsp_reverse_value  = rsp_rev_ff;
   assign rsp_hunk_start     = rsp_start_ff;
   assign rsp_index_overflow = rsp_ovf_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_stream_done    = rsp_done_ff;

   `GCDH_ASSERT(a_step_in_range, (head_valid && !null_cmd) |-> (rec_k_ff < head.rec_cnt), "record step past command")
   `GCDH_ASSERT(a_step_needs_head, (rec_k_ff != '0) |-> head_valid, "record step without command")
   `GCDH_ASSERT(a_done_is_last, (rsp_valid_ff && rsp_done_ff) |-> (rsp_last_ff && (rsp_kind_ff == KIND_CLOSE)), "end marker not last close")

endmodule

`default_nettype wire

[hdl/gap_coalescing_delta_hunk_encoder.sv]
// A transaction's first record passes the command queue and result register before
// it is offered. The record sequencer emits one record per cycle unless stalled; a
// transaction has at most GAP + 1 records; one only storing a pending pair has none.
// Single-record transactions stream one per cycle unless stalled; a four-entry command
// queue absorbs bursts. Reset is synchronous: it empties the queue and result register.
// ---------------------------------------------------------------------------
// gap_coalescing_delta_hunk_encoder
// Compares two double arrays element by element and emits delta hunks with
// short equal runs merged, plus forward and reverse tail hunks.
// ---------------------------------------------------------------------------
`default_nettype none

module gap_coalescing_delta_hunk_encoder #(
   parameter int MAX_ELEMENTS = 65536,
   parameter int GAP          = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [63:0]   req_old_value,
   input  logic [63:0]   req_new_value,
   input  logic          req_has_old,
   input  logic          req_has_new,
   input  logic          req_final_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_record_kind,
   output logic [15:0]   rsp_offset,
   output logic [63:0]   rsp_forward_value,
   output logic [63:0]   rsp_reverse_value,
   output logic          rsp_hunk_start,
   output logic          rsp_index_overflow,
   output logic          rsp_last,
   output logic          rsp_stream_done
);
   import gcdh_pkg::*;

   cmd_type   push_cmd;
   cmd_type   head_cmd;
   logic      cmd_push;
   logic      cmd_pop;
   logic      q_full;
   logic      head_valid;

   gcdh_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .GAP          (GAP)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_old_value  (req_old_value),
      .req_new_value  (req_new_value),
      .req_has_old    (req_has_old),
      .req_has_new    (req_has_new),
      .req_final_item (req_final_item),
      .q_full         (q_full),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   gcdh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (push_cmd),
      .pop        (cmd_pop),
      .head       (head_cmd),
      .head_valid (head_valid),
      .full       (q_full)
   );

   gcdh_back #(
      .GAP (GAP)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head_cmd),
      .head_valid         (head_valid),
      .pop                (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_offset         (rsp_offset),
      .rsp_forward_value  (rsp_forward_value),
      .rsp_reverse_value  (rsp_reverse_value),
      .rsp_hunk_start     (rsp_hunk_start),
      .rsp_index_overflow (rsp_index_overflow),
      .rsp_last           (rsp_last),
      .rsp_stream_done    (rsp_stream_done)
   );

endmodule

`default_nettype wire
